### design/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// shared types and codes for the bitmap frame allocator
// ----------------------------------------------------------------------------
package bfa_pkg;

  // request opcodes
  localparam logic [2:0] OP_INIT      = 3'd0;
  localparam logic [2:0] OP_FREE_RGN  = 3'd1;
  localparam logic [2:0] OP_RSV_RGN   = 3'd2;
  localparam logic [2:0] OP_ALLOC_ONE = 3'd3;
  localparam logic [2:0] OP_ALLOC_RUN = 3'd4;
  localparam logic [2:0] OP_FREE_ONE  = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOMEM  = 2'd1;
  localparam logic [1:0] ST_ZEROLEN = 2'd2;

  // widths of the block_count register, frame fields and scan chunks
  localparam int unsigned BCNT_W  = 16;
  localparam int unsigned FRAME_W = 15;
  localparam int unsigned CHUNK_W = 8;

  typedef enum logic [3:0] {
    S_FILL,
    S_IDLE,
    S_ACHK,
    S_SCAN_RD,
    S_SCAN_LD,
    S_SCAN_EV,
    S_RG_RD,
    S_RG_WR,
    S_POST,
    S_Z_RD,
    S_Z_WR,
    S_FIN,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    CNT_NONE,
    CNT_ADD,
    CNT_SUB,
    CNT_SET
  } cnt_e;

endpackage

### design/bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// first-fit physical frame allocator over a used bitmap held in one ram
// ----------------------------------------------------------------------------
// Requests come in on in_valid_i / in_stall_o with opcode, frame index and
// frame total; one result per request leaves on out_valid_o / out_stall_i.
// block_count is written through cfg_valid_i / cfg_ready_o; the user is to
// write it only while idle, as the block itself does not enforce this.
// The bitmap sits in one single port ram, one word per cycle, so every
// request is a short sequence of word reads and writes:
//   init: one write per word
//   region reserve, free one: a read and a write per word touched
//   region free: as for a reserve, then a frame 0 re-mark
//   alloc: all-used or all-free words checked whole, mixed words eight bits
//     a cycle, then the marking pass as for a region
// After reset the block writes all ones into every word of the map;
// in_stall_o is high during that pass. The result register parts the two
// sides: a new request is taken while the last result still waits, and the
// block holds its next result until the receiver lets the pending one go.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator
  import bfa_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = 32768,
  parameter int unsigned WORD_BITS  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          opcode_i,
  input  logic [FRAME_W-1:0]  frame_index_i,
  input  logic [BCNT_W-1:0]   frame_total_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [FRAME_W-1:0]  first_frame_o,
  output logic [BCNT_W-1:0]   free_frames_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [BCNT_W-1:0]   cfg_data_i
);

  localparam int unsigned MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned LWB  = $clog2(WORD_BITS);
  localparam int unsigned CW   = ($clog2(MAX_FRAMES) + 2 > 18) ? $clog2(MAX_FRAMES) + 2 : 18;
  localparam int unsigned NCH  = WORD_BITS / CHUNK_W;
  localparam int unsigned CHW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned USED_RST = (MAX_FRAMES < 32768) ? MAX_FRAMES : 32768;

  state_e               state_q, state_d;
  cnt_e                 cnt_q, cnt_d;
  logic [CW-1:0]        used_q, used_d;
  logic [BCNT_W-1:0]    bcnt_q;
  logic [CW-1:0]        idx_q, idx_d, end_q, end_d, k_q, k_d, len_q, len_d;
  logic [CW-1:0]        run_q, run_d, rstart_q, rstart_d;
  logic [AW-1:0]        cur_q, cur_d, last_q, last_d;
  logic [CHW-1:0]       sub_q, sub_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic                 set_q, set_d, remark_q, remark_d, fill_op_q, fill_op_d;
  logic [1:0]           status_q, status_d;
  logic [FRAME_W-1:0]   first_q, first_d;
  logic                 out_valid_q, out_valid_d;
  logic [1:0]           out_status_q, out_status_d;
  logic [FRAME_W-1:0]   out_first_q, out_first_d;
  logic [BCNT_W-1:0]    out_free_q, out_free_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic [CW-1:0]        n_w, free_w, endm1_w, base_w, lim_w;

  // effective frame count and free count
  assign n_w     = (CW'(bcnt_q) < CW'(MAX_FRAMES)) ? CW'(bcnt_q) : CW'(MAX_FRAMES);
  assign free_w  = (used_q < n_w) ? n_w - used_q : '0;
  assign endm1_w = end_q - CW'(1);
  assign base_w  = CW'(cur_q) << LWB;
  assign lim_w   = n_w - base_w;

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // sequencer: next state, datapath and ram control
  always_comb begin
    logic [CW-1:0]        r, s, tot_w, idx_w, e_w;
    logic                 fnd, wdone;
    logic [CHUNK_W-1:0]   ch;
    logic [LWB:0]         lo, hi;
    logic [WORD_BITS-1:0] msk;

    state_d      = state_q;
    cnt_d        = cnt_q;
    used_d       = used_q;
    idx_d        = idx_q;
    end_d        = end_q;
    k_d          = k_q;
    len_d        = len_q;
    run_d        = run_q;
    rstart_d     = rstart_q;
    cur_d        = cur_q;
    last_d       = last_q;
    sub_d        = sub_q;
    word_d       = word_q;
    set_d        = set_q;
    remark_d     = remark_q;
    fill_op_d    = fill_op_q;
    status_d     = status_q;
    first_d      = first_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_status_d = out_status_q;
    out_first_d  = out_first_q;
    out_free_d   = out_free_q;
    ram_we       = 1'b0;
    ram_addr     = cur_q;
    ram_wdata    = '0;
    r            = run_q;
    s            = rstart_q;
    fnd          = 1'b0;
    wdone        = 1'b0;
    ch           = '0;
    lo           = '0;
    hi           = '0;
    msk          = '0;
    tot_w        = CW'(frame_total_i);
    idx_w        = CW'(frame_index_i);
    e_w          = idx_w + tot_w;

    case (state_q)
      // write all ones into every map word
      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = {WORD_BITS{1'b1}};
        cur_d     = cur_q + AW'(1);
        if (cur_q == AW'(MAP_WORDS - 1)) begin
          state_d = fill_op_q ? S_FIN : S_IDLE;
        end
      end

      // request decode
      S_IDLE: begin
        if (in_valid_i) begin
          status_d  = ST_OK;
          first_d   = '0;
          cnt_d     = CNT_NONE;
          remark_d  = 1'b0;
          fill_op_d = 1'b0;
          case (opcode_i)
            OP_INIT: begin
              fill_op_d = 1'b1;
              cnt_d     = CNT_SET;
              cur_d     = '0;
              state_d   = S_FILL;
            end
            OP_FREE_RGN, OP_RSV_RGN: begin
              if (tot_w == '0) begin
                status_d = ST_ZEROLEN;
                state_d  = S_OUT;
              end else begin
                idx_d    = idx_w;
                end_d    = (e_w > n_w) ? n_w : e_w;
                set_d    = (opcode_i == OP_RSV_RGN);
                remark_d = (opcode_i == OP_FREE_RGN);
                cnt_d    = (opcode_i == OP_RSV_RGN) ? CNT_ADD : CNT_SUB;
                cur_d    = idx_w[LWB +: AW];
                if (e_w > idx_w && n_w > idx_w) begin
                  k_d     = ((e_w > n_w) ? n_w : e_w) - idx_w;
                  state_d = S_RG_RD;
                end else begin
                  k_d     = '0;
                  state_d = S_POST;
                end
              end
            end
            OP_ALLOC_ONE, OP_ALLOC_RUN: begin
              len_d = (opcode_i == OP_ALLOC_ONE) ? CW'(1) : tot_w;
              if (opcode_i == OP_ALLOC_RUN && tot_w == '0) begin
                status_d = ST_ZEROLEN;
                state_d  = S_OUT;
              end else begin
                state_d = S_ACHK;
              end
            end
            OP_FREE_ONE: begin
              if (idx_w < n_w) begin
                idx_d   = idx_w;
                end_d   = idx_w + CW'(1);
                k_d     = CW'(1);
                set_d   = 1'b0;
                cnt_d   = CNT_SUB;
                cur_d   = idx_w[LWB +: AW];
                state_d = S_RG_RD;
              end else begin
                state_d = S_OUT;
              end
            end
            default: begin
              state_d = S_OUT;
            end
          endcase
        end
      end

      // room check before the scan
      S_ACHK: begin
        if (n_w == '0 || free_w < len_q) begin
          status_d = ST_NOMEM;
          state_d  = S_OUT;
        end else begin
          cur_d   = '0;
          run_d   = '0;
          last_d  = AW'((n_w - CW'(1)) >> LWB);
          state_d = S_SCAN_RD;
        end
      end

      S_SCAN_RD: begin
        state_d = S_SCAN_LD;
      end

      // latch word, frames beyond the managed count read as used
      S_SCAN_LD: begin
        if (lim_w[CW-1:LWB] != '0) begin
          word_d = ram_rdata;
        end else begin
          word_d = ram_rdata | ({WORD_BITS{1'b1}} << lim_w[LWB-1:0]);
        end
        sub_d   = '0;
        state_d = S_SCAN_EV;
      end

      // run search, whole word when uniform, else eight bits a cycle
      S_SCAN_EV: begin
        if (sub_q == '0 && &word_q) begin
          r     = '0;
          wdone = 1'b1;
        end else if (sub_q == '0 && ~|word_q) begin
          if (run_q == '0) begin
            s = base_w;
          end
          if (run_q + CW'(WORD_BITS) >= len_q) begin
            fnd = 1'b1;
          end
          r     = run_q + CW'(WORD_BITS);
          wdone = 1'b1;
        end else begin
          ch = CHUNK_W'(word_q >> (32'(sub_q) << 3));
          for (int j = 0; j < CHUNK_W; j++) begin
            if (!fnd) begin
              if (ch[j]) begin
                r = '0;
              end else begin
                if (r == '0) begin
                  s = base_w + (CW'(sub_q) << 3) + CW'(j);
                end
                r = r + CW'(1);
                if (r == len_q) begin
                  fnd = 1'b1;
                end
              end
            end
          end
          wdone = (sub_q == CHW'(NCH - 1));
        end
        run_d    = r;
        rstart_d = s;
        sub_d    = sub_q + CHW'(1);
        if (fnd) begin
          idx_d    = s;
          end_d    = s + len_q;
          k_d      = len_q;
          first_d  = s[FRAME_W-1:0];
          set_d    = 1'b1;
          remark_d = 1'b0;
          cnt_d    = CNT_ADD;
          cur_d    = s[LWB +: AW];
          state_d  = S_RG_RD;
        end else if (wdone) begin
          if (cur_q == last_q) begin
            status_d = ST_NOMEM;
            state_d  = S_OUT;
          end else begin
            cur_d   = cur_q + AW'(1);
            state_d = S_SCAN_RD;
          end
        end
      end

      S_RG_RD: begin
        state_d = S_RG_WR;
      end

      // read-modify-write of one word of the region
      S_RG_WR: begin
        lo = (cur_q == idx_q[LWB +: AW]) ? {1'b0, idx_q[LWB-1:0]} : '0;
        hi = (cur_q == endm1_w[LWB +: AW]) ? {1'b0, endm1_w[LWB-1:0]}
                                           : (LWB+1)'(WORD_BITS - 1);
        for (int j = 0; j < WORD_BITS; j++) begin
          msk[j] = ((LWB+1)'(j) >= lo) && ((LWB+1)'(j) <= hi);
        end
        ram_we    = 1'b1;
        ram_wdata = set_q ? (ram_rdata | msk) : (ram_rdata & ~msk);
        if (cur_q == endm1_w[LWB +: AW]) begin
          state_d = S_POST;
        end else begin
          cur_d   = cur_q + AW'(1);
          state_d = S_RG_RD;
        end
      end

      // frame 0 stays used after a region free
      S_POST: begin
        state_d = (remark_q && n_w != '0) ? S_Z_RD : S_FIN;
      end

      S_Z_RD: begin
        ram_addr = '0;
        state_d  = S_Z_WR;
      end

      S_Z_WR: begin
        ram_addr  = '0;
        ram_we    = 1'b1;
        ram_wdata = ram_rdata | WORD_BITS'(1);
        state_d   = S_FIN;
      end

      // saturating used count update
      S_FIN: begin
        case (cnt_q)
          CNT_ADD: begin
            used_d = (used_q >= n_w || n_w - used_q < k_q) ? n_w : used_q + k_q;
          end
          CNT_SUB: begin
            used_d = (used_q > k_q) ? used_q - k_q : '0;
          end
          CNT_SET: begin
            used_d = n_w;
          end
          default: begin
            used_d = used_q;
          end
        endcase
        state_d = S_OUT;
      end

      // load the result register once it is free
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_first_d  = first_q;
          out_free_d   = free_w[BCNT_W-1:0];
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      cur_q       <= '0;
      fill_op_q   <= 1'b0;
      used_q      <= CW'(USED_RST);
      bcnt_q      <= BCNT_W'(32768);
      out_valid_q <= 1'b0;
      cnt_q       <= CNT_NONE;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      fill_op_q   <= fill_op_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_valid_i) begin
        bcnt_q <= cfg_data_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    end_q        <= end_d;
    k_q          <= k_d;
    len_q        <= len_d;
    run_q        <= run_d;
    rstart_q     <= rstart_d;
    last_q       <= last_d;
    sub_q        <= sub_d;
    word_q       <= word_d;
    set_q        <= set_d;
    remark_q     <= remark_d;
    status_q     <= status_d;
    first_q      <= first_d;
    out_status_q <= out_status_d;
    out_first_q  <= out_first_d;
    out_free_q   <= out_free_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign first_frame_o = out_first_q;
  assign free_frames_o = out_free_q;

endmodule

### design/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// single port ram, one write or read per cycle, registered read data
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
